FILE: hdl/c2pa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2pa_pkg: shared types and constants for the pointing-angle converter
// Fixed-point formats, the CORDIC arc-tangent table and the sideband
// structures that travel alongside each word through the pipeline.
// ----------------------------------------------------------------------------
package c2pa_pkg;

  // Field widths of the stream words.
  localparam int COORD_BITS        = 16;
  localparam int ANGLE_FRAC_BITS   = 8;
  localparam int AZ_W              = 17;
  localparam int EL_W              = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // Coordinates are scaled up by 2^GUARD before the CORDIC.
  localparam int GUARD     = (COORD_BITS < 31) ? 31 - COORD_BITS : 0;
  localparam int SUM_BITS  = 2 * COORD_BITS;
  localparam int ROOT_BITS = COORD_BITS + GUARD;
  localparam int VEC_W     = ROOT_BITS + 3;

  // Angle accumulator in units of 2^-24 degree.
  localparam int ACC_FRAC    = 24;
  localparam int ACC_W       = 34;
  localparam int ROUND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int ROUND_W     = ACC_W - ROUND_SHIFT;

  // Two CORDIC lanes run side by side.
  localparam int LANES   = 2;
  localparam int LANE_AZ = 0;
  localparam int LANE_EL = 1;

  // Square-root digits resolved per pipeline stage.
  localparam int SQRT_STEPS = 2;

  // Stream word widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((AZ_W + EL_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - AZ_W - EL_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [VEC_W-1:0]      vec_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [ROUND_W-1:0]    round_t;
  typedef logic signed [AZ_W-1:0]       az_t;
  typedef logic signed [EL_W-1:0]       el_t;

  typedef struct packed {
    logic xy_zero;
    logic all_zero;
  } flags_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    flags_t flags;
  } side_t;

  localparam acc_t   ACC_NINETY = acc_t'(90 * (2 ** ACC_FRAC));
  localparam acc_t   ACC_HALF   = acc_t'(2 ** (ROUND_SHIFT - 1));
  localparam round_t LIM180     = round_t'(180 * (2 ** ANGLE_FRAC_BITS));
  localparam round_t LIM90      = round_t'(90 * (2 ** ANGLE_FRAC_BITS));

  // atan(2^-i) in units of 2^-24 degree, rounded to nearest.
  function automatic acc_t atan_deg(input int idx);
    case (idx)
      0:       atan_deg = acc_t'(754974720);
      1:       atan_deg = acc_t'(445687602);
      2:       atan_deg = acc_t'(235489088);
      3:       atan_deg = acc_t'(119537938);
      4:       atan_deg = acc_t'(60000934);
      5:       atan_deg = acc_t'(30029717);
      6:       atan_deg = acc_t'(15018523);
      7:       atan_deg = acc_t'(7509720);
      8:       atan_deg = acc_t'(3754917);
      9:       atan_deg = acc_t'(1877466);
      10:      atan_deg = acc_t'(938734);
      11:      atan_deg = acc_t'(469367);
      12:      atan_deg = acc_t'(234684);
      13:      atan_deg = acc_t'(117342);
      14:      atan_deg = acc_t'(58671);
      15:      atan_deg = acc_t'(29335);
      16:      atan_deg = acc_t'(14668);
      17:      atan_deg = acc_t'(7334);
      18:      atan_deg = acc_t'(3667);
      19:      atan_deg = acc_t'(1833);
      20:      atan_deg = acc_t'(917);
      21:      atan_deg = acc_t'(458);
      22:      atan_deg = acc_t'(229);
      23:      atan_deg = acc_t'(115);
      24:      atan_deg = acc_t'(57);
      25:      atan_deg = acc_t'(29);
      26:      atan_deg = acc_t'(14);
      27:      atan_deg = acc_t'(7);
      28:      atan_deg = acc_t'(4);
      29:      atan_deg = acc_t'(2);
      30:      atan_deg = acc_t'(1);
      default: atan_deg = '0;
    endcase
  endfunction

endpackage

FILE: hdl/c2pa_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2pa_isqrt: pipelined integer square root
// Returns floor(sqrt(sum * 2^(2*GUARD))) by the digit-by-digit method,
// resolving two root bits per register stage. A sideband travels with it.
// ----------------------------------------------------------------------------
module c2pa_isqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [c2pa_pkg::SUM_BITS-1:0]    in_sum,
  input  c2pa_pkg::side_t                  in_side,
  output logic                             out_valid,
  output logic [c2pa_pkg::ROOT_BITS-1:0]   out_root,
  output c2pa_pkg::side_t                  out_side
);

  localparam int RB         = c2pa_pkg::ROOT_BITS;
  localparam int NUM_STAGES = (RB + c2pa_pkg::SQRT_STEPS - 1) / c2pa_pkg::SQRT_STEPS;
  localparam int REM_W      = RB + 1;
  localparam int PART_W     = RB + 3;

  typedef logic [RB-1:0]    root_t;
  typedef logic [REM_W-1:0] rem_t;

  // Index 0 is the input; index s+1 is the register after stage s.
  logic                            valid [NUM_STAGES+1];
  root_t                           q     [NUM_STAGES+1];
  rem_t                            rem   [NUM_STAGES+1];
  logic [c2pa_pkg::SUM_BITS-1:0]   sum   [NUM_STAGES+1];
  c2pa_pkg::side_t                 side  [NUM_STAGES+1];

  // Two bits of the scaled radicand, counted from the top pair down.
  // The low 2*GUARD bits of the scaled radicand are zero.
  function automatic logic [1:0] pair_at(input logic [c2pa_pkg::SUM_BITS-1:0] s,
                                         input int k);
    int pos;
    pos = RB - 1 - k;
    if (pos >= c2pa_pkg::GUARD) begin
      pair_at = s[2 * (pos - c2pa_pkg::GUARD) +: 2];
    end else begin
      pair_at = 2'b00;
    end
  endfunction

  assign valid[0] = in_valid;
  assign q[0]     = '0;
  assign rem[0]   = '0;
  assign sum[0]   = in_sum;
  assign side[0]  = in_side;

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    root_t q_w;
    rem_t  rem_w;

    // Resolve this stage's root digits: trial subtract against 4q+1.
    always_comb begin
      logic [PART_W-1:0] part;
      logic [PART_W-1:0] trial;
      logic [PART_W-1:0] diff;
      q_w   = q[s];
      rem_w = rem[s];
      part  = '0;
      trial = '0;
      diff  = '0;
      for (int j = 0; j < c2pa_pkg::SQRT_STEPS; j++) begin
        if (s * c2pa_pkg::SQRT_STEPS + j < RB) begin
          part  = {rem_w, pair_at(sum[s], s * c2pa_pkg::SQRT_STEPS + j)};
          trial = {1'b0, q_w, 2'b01};
          diff  = part - trial;
          if (part >= trial) begin
            rem_w = diff[REM_W-1:0];
            q_w   = {q_w[RB-2:0], 1'b1};
          end else begin
            rem_w = part[REM_W-1:0];
            q_w   = {q_w[RB-2:0], 1'b0};
          end
        end
      end
    end

    // Valid bit of the stage.
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s+1] <= 1'b0;
      end else if (en) begin
        valid[s+1] <= valid[s];
      end
    end

    // Payload of the stage.
    always_ff @(posedge clk) begin
      if (en) begin
        q[s+1]    <= q_w;
        rem[s+1]  <= rem_w;
        sum[s+1]  <= sum[s];
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = valid[NUM_STAGES];
  assign out_root  = q[NUM_STAGES];
  assign out_side  = side[NUM_STAGES];

endmodule

FILE: hdl/c2pa_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2pa_cordic: pipelined vectoring CORDIC, two lanes
// Each lane returns atan2(b, a) in units of 2^-24 degree. One register
// stage turns the left half plane by +/-90 degrees, then one stage per
// micro-rotation.
// ----------------------------------------------------------------------------
module c2pa_cordic #(
  parameter int STAGES = c2pa_pkg::CORDIC_STAGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  c2pa_pkg::flags_t  in_flags,
  input  c2pa_pkg::vec_t    in_a [c2pa_pkg::LANES],
  input  c2pa_pkg::vec_t    in_b [c2pa_pkg::LANES],
  output logic              out_valid,
  output c2pa_pkg::flags_t  out_flags,
  output c2pa_pkg::acc_t    out_acc [c2pa_pkg::LANES]
);

  localparam int MSB = c2pa_pkg::VEC_W - 1;

  logic             valid [STAGES+1];
  c2pa_pkg::flags_t flags [STAGES+1];
  c2pa_pkg::vec_t   a     [STAGES+1][c2pa_pkg::LANES];
  c2pa_pkg::vec_t   b     [STAGES+1][c2pa_pkg::LANES];
  c2pa_pkg::acc_t   acc   [STAGES+1][c2pa_pkg::LANES];

  // Pre-rotation valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
    end
  end

  // Pre-rotation: bring a vector with a < 0 into the right half plane.
  always_ff @(posedge clk) begin
    if (en) begin
      flags[0] <= in_flags;
      for (int l = 0; l < c2pa_pkg::LANES; l++) begin
        if (in_a[l][MSB]) begin
          if (!in_b[l][MSB]) begin
            a[0][l]   <= in_b[l];
            b[0][l]   <= -in_a[l];
            acc[0][l] <= c2pa_pkg::ACC_NINETY;
          end else begin
            a[0][l]   <= -in_b[l];
            b[0][l]   <= in_a[l];
            acc[0][l] <= -c2pa_pkg::ACC_NINETY;
          end
        end else begin
          a[0][l]   <= in_a[l];
          b[0][l]   <= in_b[l];
          acc[0][l] <= '0;
        end
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    // Valid bit of the micro-rotation stage.
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else if (en) begin
        valid[i+1] <= valid[i];
      end
    end

    // Rotate towards b = 0 by atan(2^-i).
    always_ff @(posedge clk) begin
      if (en) begin
        flags[i+1] <= flags[i];
        for (int l = 0; l < c2pa_pkg::LANES; l++) begin
          if (!b[i][l][MSB]) begin
            a[i+1][l]   <= a[i][l] + (b[i][l] >>> i);
            b[i+1][l]   <= b[i][l] - (a[i][l] >>> i);
            acc[i+1][l] <= acc[i][l] + c2pa_pkg::atan_deg(i);
          end else begin
            a[i+1][l]   <= a[i][l] - (b[i][l] >>> i);
            b[i+1][l]   <= b[i][l] + (a[i][l] >>> i);
            acc[i+1][l] <= acc[i][l] - c2pa_pkg::atan_deg(i);
          end
        end
      end
    end
  end

  assign out_valid = valid[STAGES];
  assign out_flags = flags[STAGES];

  always_comb begin
    for (int l = 0; l < c2pa_pkg::LANES; l++) begin
      out_acc[l] = acc[STAGES][l];
    end
  end

endmodule

FILE: hdl/cartesian_to_pointing_angles_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_pointing_angles_top: azimuth and elevation of a target point
// Converts a Cartesian point into azimuth atan2(y, x) and elevation
// atan2(z, sqrt(x^2 + y^2)) in units of 1/256 degree.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side s_axis_*: one word per point, x, y and z as signed integers.
//   Master side m_axis_*: one word per point, azimuth then elevation.
//   A word is taken on any edge where tvalid and tready are both high.
//   Throughput: one word per clock cycle, sustained while the receiver does not stall.
//   Pipeline: the result word passes through, in order, two stages that form
//   x^2 + y^2, sixteen stages of the square root that resolve up to two
//   root bits each, one stage that turns the left half plane, one stage per
//   CORDIC micro-rotation, and the output register.
//   When the receiver stalls with a word waiting, the whole pipeline holds
//   and s_axis_tready falls; no word is lost or repeated.
//   Reset clears every valid bit, so no word is presented after reset.
//   The zero vector gives both angles zero; azimuth -180 reads as +180.
// ----------------------------------------------------------------------------
module cartesian_to_pointing_angles_top #(
  parameter int CORDIC_STAGES = c2pa_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] coord_x, [31:16] coord_y, [47:32] coord_z
  input  logic [c2pa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [16:0] azimuth_angle, [32:17] elevation_angle, [39:33] zero
  output logic [c2pa_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int CB = c2pa_pkg::COORD_BITS;
  localparam int SB = c2pa_pkg::SUM_BITS;

  // Global pipeline advance: move whenever the output register can be refilled.
  logic advance;
  logic in_accept;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign in_accept     = s_axis_tvalid && advance;

  // Unpack the input word.
  c2pa_pkg::coord_t in_x;
  c2pa_pkg::coord_t in_y;
  c2pa_pkg::coord_t in_z;
  logic signed [SB-1:0] prod_x;
  logic signed [SB-1:0] prod_y;

  assign in_x   = s_axis_tdata[CB-1:0];
  assign in_y   = s_axis_tdata[2*CB-1:CB];
  assign in_z   = s_axis_tdata[3*CB-1:2*CB];
  assign prod_x = SB'(in_x) * SB'(in_x);
  assign prod_y = SB'(in_y) * SB'(in_y);

  // Stage 1: squares and zero flags.
  logic            v1;
  c2pa_pkg::side_t side1;
  logic [SB-1:0]   sq_x;
  logic [SB-1:0]   sq_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      side1.x              <= in_x;
      side1.y              <= in_y;
      side1.z              <= in_z;
      side1.flags.xy_zero  <= (in_x == '0) && (in_y == '0);
      side1.flags.all_zero <= (in_x == '0) && (in_y == '0) && (in_z == '0);
      sq_x                 <= prod_x;
      sq_y                 <= prod_y;
    end
  end

  // Stage 2: sum of squares.
  logic            v2;
  c2pa_pkg::side_t side2;
  logic [SB-1:0]   sum2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      side2 <= side1;
      sum2  <= sq_x + sq_y;
    end
  end

  // Length of the xy projection.
  logic                                 sq_valid;
  logic [c2pa_pkg::ROOT_BITS-1:0]       sq_root;
  c2pa_pkg::side_t                      sq_side;

  c2pa_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (v2),
    .in_sum    (sum2),
    .in_side   (side2),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Both angles from one two-lane CORDIC.
  c2pa_pkg::vec_t   cord_a   [c2pa_pkg::LANES];
  c2pa_pkg::vec_t   cord_b   [c2pa_pkg::LANES];
  logic             cord_valid;
  c2pa_pkg::flags_t cord_flags;
  c2pa_pkg::acc_t   cord_acc [c2pa_pkg::LANES];

  assign cord_a[c2pa_pkg::LANE_AZ] = c2pa_pkg::vec_t'(sq_side.x) <<< c2pa_pkg::GUARD;
  assign cord_b[c2pa_pkg::LANE_AZ] = c2pa_pkg::vec_t'(sq_side.y) <<< c2pa_pkg::GUARD;
  assign cord_a[c2pa_pkg::LANE_EL] = c2pa_pkg::vec_t'(sq_root);
  assign cord_b[c2pa_pkg::LANE_EL] = c2pa_pkg::vec_t'(sq_side.z) <<< c2pa_pkg::GUARD;

  c2pa_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (sq_valid),
    .in_flags  (sq_side.flags),
    .in_a      (cord_a),
    .in_b      (cord_b),
    .out_valid (cord_valid),
    .out_flags (cord_flags),
    .out_acc   (cord_acc)
  );

  // Round to nearest, ties upwards, into the output units.
  function automatic c2pa_pkg::round_t round_angle(input c2pa_pkg::acc_t acc);
    c2pa_pkg::acc_t biased;
    biased      = acc + c2pa_pkg::ACC_HALF;
    round_angle = c2pa_pkg::round_t'(biased >>> c2pa_pkg::ROUND_SHIFT);
  endfunction

  c2pa_pkg::round_t az_round;
  c2pa_pkg::round_t el_round;
  c2pa_pkg::round_t az_next;
  c2pa_pkg::round_t el_next;

  // Zero cases, the -180 wrap and the saturation at the poles.
  always_comb begin
    az_round = round_angle(cord_acc[c2pa_pkg::LANE_AZ]);
    el_round = round_angle(cord_acc[c2pa_pkg::LANE_EL]);

    if (cord_flags.xy_zero) begin
      az_next = '0;
    end else if (az_round <= -c2pa_pkg::LIM180 || az_round > c2pa_pkg::LIM180) begin
      az_next = c2pa_pkg::LIM180;
    end else begin
      az_next = az_round;
    end

    if (cord_flags.all_zero) begin
      el_next = '0;
    end else if (el_round > c2pa_pkg::LIM90) begin
      el_next = c2pa_pkg::LIM90;
    end else if (el_round < -c2pa_pkg::LIM90) begin
      el_next = -c2pa_pkg::LIM90;
    end else begin
      el_next = el_round;
    end
  end

  // Output register.
  c2pa_pkg::az_t az_q;
  c2pa_pkg::el_t el_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= cord_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      az_q <= az_next[c2pa_pkg::AZ_W-1:0];
      el_q <= el_next[c2pa_pkg::EL_W-1:0];
    end
  end

  assign m_axis_tdata = {{c2pa_pkg::OUT_PAD_W{1'b0}}, el_q, az_q};

  // Checks on the angle logic.
  a_az_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (az_q > -c2pa_pkg::LIM180 && az_q <= c2pa_pkg::LIM180))
    else $error("azimuth outside (-180, 180] degrees");

  a_el_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (el_q >= -c2pa_pkg::LIM90 && el_q <= c2pa_pkg::LIM90))
    else $error("elevation outside [-90, 90] degrees");

  a_xy_zero_az: assert property (@(posedge clk) disable iff (rst)
    (advance && cord_valid && cord_flags.xy_zero) |=> (az_q == '0))
    else $error("azimuth not zero for a point on the z axis");

  a_zero_vec_el: assert property (@(posedge clk) disable iff (rst)
    (advance && cord_valid && cord_flags.all_zero) |=> (el_q == '0))
    else $error("elevation not zero for the zero vector");

endmodule

FILE: tb/tb_cartesian_to_pointing_angles_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartesian_to_pointing_angles_top: self-checking bench for the converter
// Streams target points into the converter, with random gaps on the input
// and random back-pressure on the output. Every accepted point is run
// through a bit-exact model of the two vectoring CORDICs here, and each
// result word is compared field by field, in order, with the oldest pending
// pair of angles. A short directed table covers the axes, the corners of the
// coordinate range, the branch cut at 180 degrees and the zero vector.
// Random points follow.
// ----------------------------------------------------------------------------
module tb_cartesian_to_pointing_angles_top;

  localparam int     STAGES       = 16;
  localparam int     SCALE_SHIFT  = 15;           // 31 - coordinate width
  localparam int     FRAC_SHIFT   = 16;           // 2^-24 degree down to 2^-8
  localparam longint HALF_DEG_LSB = 64'sd32768;   // half an output LSB
  localparam longint DEG_180      = 64'sd46080;
  localparam longint DEG_90       = 64'sd23040;
  localparam int     NUM_DIRECTED = 20;
  localparam int     NUM_RANDOM   = 1430;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     STALL_LIMIT  = 2000;

  typedef struct packed {
    c2pa_pkg::az_t az;
    c2pa_pkg::el_t el;
  } angles_t;

  typedef struct {
    c2pa_pkg::coord_t x;
    c2pa_pkg::coord_t y;
    c2pa_pkg::coord_t z;
    bit               typed;
    angles_t          angles;
  } point_row_t;

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [c2pa_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [c2pa_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  angles_t    pending_angles [$];
  point_row_t directed_points [0:NUM_DIRECTED-1];
  int         idle_pct        = 24;
  int         mismatch_count  = 0;
  int         quiet_cycles    = 0;

  cartesian_to_pointing_angles_top #(
    .CORDIC_STAGES(STAGES)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Micro-rotation angles atan(2^-i), in units of 2^-24 degree.
  function automatic longint arctan_step(input int idx);
    case (idx)
      0:       arctan_step = 754974720;
      1:       arctan_step = 445687602;
      2:       arctan_step = 235489088;
      3:       arctan_step = 119537938;
      4:       arctan_step = 60000934;
      5:       arctan_step = 30029717;
      6:       arctan_step = 15018523;
      7:       arctan_step = 7509720;
      8:       arctan_step = 3754917;
      9:       arctan_step = 1877466;
      10:      arctan_step = 938734;
      11:      arctan_step = 469367;
      12:      arctan_step = 234684;
      13:      arctan_step = 117342;
      14:      arctan_step = 58671;
      15:      arctan_step = 29335;
      default: arctan_step = 0;
    endcase
  endfunction

  // Bit-by-bit integer square root, rounded down.
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'h1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n    = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Vectoring CORDIC: atan2(b, a) in units of 2^-24 degree, rounded to the
  // output LSB with ties going upwards.
  function automatic longint rounded_atan2(input longint a_in, input longint b_in);
    longint a;
    longint b;
    longint held;
    longint da;
    longint db;
    longint acc;
    int     i;
    a   = a_in;
    b   = b_in;
    acc = 0;
    // The left half plane is turned by a quarter turn first.
    if (a < 0) begin
      held = a;
      if (b >= 0) begin
        a   = b;
        b   = -held;
        acc = longint'(90) <<< 24;
      end else begin
        a   = -b;
        b   = held;
        acc = -(longint'(90) <<< 24);
      end
    end
    for (i = 0; i < STAGES; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a   = a + da;
        b   = b - db;
        acc = acc + arctan_step(i);
      end else begin
        a   = a - da;
        b   = b + db;
        acc = acc - arctan_step(i);
      end
    end
    return (acc + HALF_DEG_LSB) >>> FRAC_SHIFT;
  endfunction

  // Azimuth and elevation that the converter must give for one point.
  function automatic angles_t point_angles(input c2pa_pkg::coord_t x,
                                           input c2pa_pkg::coord_t y,
                                           input c2pa_pkg::coord_t z);
    longint          xs;
    longint          ys;
    longint          zs;
    longint          az;
    longint          el;
    longint unsigned radius_sq;
    angles_t         result;
    xs = x;
    ys = y;
    zs = z;
    az = 0;
    el = 0;
    if (xs != 0 || ys != 0) begin
      az = rounded_atan2(xs <<< SCALE_SHIFT, ys <<< SCALE_SHIFT);
      // Minus 180 degrees folds onto plus 180.
      if (az <= -DEG_180 || az > DEG_180) az = DEG_180;
    end
    if (xs != 0 || ys != 0 || zs != 0) begin
      radius_sq = longint'(xs * xs + ys * ys) << (2 * SCALE_SHIFT);
      el = rounded_atan2(longint'(root_floor(radius_sq)), zs <<< SCALE_SHIFT);
      if (el > DEG_90) el = DEG_90;
      if (el < -DEG_90) el = -DEG_90;
    end
    result.az = az[16:0];
    result.el = el[15:0];
    return result;
  endfunction

  // Coordinate drawn from a mix of full range, small values and extremes.
  function automatic c2pa_pkg::coord_t random_coord();
    case ($urandom_range(9))
      0, 1, 2, 3: random_coord = c2pa_pkg::coord_t'($urandom);
      4, 5:       random_coord = c2pa_pkg::coord_t'(int'($urandom_range(64)) - 32);
      6:          random_coord = '0;
      7:          random_coord = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      8:          random_coord = c2pa_pkg::coord_t'($urandom) >>> $urandom_range(15);
      default:    random_coord = $urandom_range(1) ? 16'sd1 : -16'sd1;
    endcase
  endfunction

  // Presents one word and waits for it to be taken, with random gaps ahead.
  task automatic send_point(input c2pa_pkg::coord_t x, input c2pa_pkg::coord_t y,
                            input c2pa_pkg::coord_t z,
                            input bit typed, input angles_t typed_angles);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_angles.push_back(typed ? typed_angles : point_angles(x, y, z));
  endtask

  // Holds the input side quiet until every pending result has come back.
  task automatic drain_pending();
    s_axis_tvalid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
  endtask

  // Random back-pressure on the result side.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Result checker and stall watchdog.
  always @(posedge clk) begin : check_results
    angles_t       want;
    c2pa_pkg::az_t got_az;
    c2pa_pkg::el_t got_el;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_az = m_axis_tdata[16:0];
        got_el = m_axis_tdata[32:17];
        if (pending_angles.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word, azimuth %0d elevation %0d", $time, got_az, got_el);
        end else begin
          want = pending_angles.pop_front();
          if (got_az !== want.az) begin
            mismatch_count++;
            $display("%0t: azimuth expected %0d actual %0d", $time, want.az, got_az);
          end
          if (got_el !== want.el) begin
            mismatch_count++;
            $display("%0t: elevation expected %0d actual %0d", $time, want.el, got_el);
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin : stimulus
    c2pa_pkg::coord_t x;
    c2pa_pkg::coord_t y;
    c2pa_pkg::coord_t z;
    int               n;

    // Axes, corners, the branch cut near 180 degrees and the zero vector.
    directed_points[0]  = '{16'sd0,      16'sd0,      16'sd0,      1'b1, '{17'sd0, 16'sd0}};
    directed_points[1]  = '{16'sd32767,  16'sd0,      16'sd0,      1'b0, '0};
    directed_points[2]  = '{-16'sd32768, 16'sd0,      16'sd0,      1'b0, '0};
    directed_points[3]  = '{-16'sd32768, -16'sd1,     16'sd0,      1'b0, '0};
    directed_points[4]  = '{-16'sd1,     16'sd0,      16'sd0,      1'b0, '0};
    directed_points[5]  = '{-16'sd32768, 16'sd1,      16'sd0,      1'b0, '0};
    directed_points[6]  = '{16'sd0,      16'sd32767,  16'sd0,      1'b0, '0};
    directed_points[7]  = '{16'sd0,      -16'sd32768, 16'sd0,      1'b0, '0};
    directed_points[8]  = '{16'sd0,      16'sd1,      16'sd0,      1'b0, '0};
    directed_points[9]  = '{-16'sd1,     16'sd1,      16'sd0,      1'b0, '0};
    directed_points[10] = '{-16'sd1,     -16'sd1,     -16'sd1,     1'b0, '0};
    directed_points[11] = '{16'sd0,      16'sd0,      16'sd32767,  1'b0, '0};
    directed_points[12] = '{16'sd0,      16'sd0,      -16'sd32768, 1'b0, '0};
    directed_points[13] = '{16'sd0,      16'sd0,      16'sd1,      1'b0, '0};
    directed_points[14] = '{16'sd1,      16'sd0,      -16'sd32768, 1'b0, '0};
    directed_points[15] = '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, '0};
    directed_points[16] = '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0};
    directed_points[17] = '{-16'sd32768, -16'sd32768, 16'sd32767,  1'b0, '0};
    directed_points[18] = '{-16'sd32768, 16'sd32767,  16'sd1,      1'b0, '0};
    directed_points[19] = '{16'sd12345,  -16'sd23456, 16'sd345,    1'b0, '0};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < NUM_DIRECTED; n++) begin
      send_point(directed_points[n].x, directed_points[n].y, directed_points[n].z,
                 directed_points[n].typed, directed_points[n].angles);
    end
    drain_pending();

    for (n = 0; n < NUM_RANDOM; n++) begin
      // A long stretch with no gaps and no back-pressure at all.
      idle_pct = (n >= 500 && n < 800) ? 0 : 24;
      if (n == 900) drain_pending();
      x = random_coord();
      y = random_coord();
      z = random_coord();
      case ($urandom_range(7))
        // Close to the x axis, which crosses the branch cut when x < 0.
        0:       y = c2pa_pkg::coord_t'(int'($urandom_range(2)) - 1);
        // Straight up or down.
        1: begin
          x = '0;
          y = '0;
        end
        2:       z = '0;
        default: ;
      endcase
      send_point(x, y, z, 1'b0, '0);
    end

    drain_pending();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
